// ===== sv/led_digit_chain_command_framer_defines.svh =====
// Assertion helpers for the LED digit chain framer.
`ifndef LED_DIGIT_CHAIN_COMMAND_FRAMER_DEFINES_SVH
`define LED_DIGIT_CHAIN_COMMAND_FRAMER_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define LDF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ldf check failed");

// Next-cycle implication, disabled in reset
`define LDF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ldf check failed");

`endif

// ===== sv/ldf_pkg.sv =====
package ldf_pkg;

   // chain limits
   localparam int unsigned MAX_CHAIN       = 8;
   localparam int unsigned DIGITS_PER_CHIP = 8;
   localparam int unsigned FRAME_CAP       = 64 / DIGITS_PER_CHIP;
   localparam int unsigned CHAIN_CAP       = (MAX_CHAIN < FRAME_CAP) ? MAX_CHAIN : FRAME_CAP;
   localparam int unsigned QUEUE_DEPTH     = 4;

   // chip register and data codes
   localparam logic [3:0] INTENSITY_REG = 4'h0A;
   localparam logic [7:0] MAX_INTENSITY = 8'h0F;
   localparam logic [7:0] BLANK_CODE    = 8'h0F;
   localparam logic [7:0] DP_BIT        = 8'h80;

   // characters
   localparam logic [7:0] CHAR_NUL = 8'h00;
   localparam logic [7:0] CHAR_DOT = 8'h2E;

   typedef enum logic [1:0] {
      REQ_DIGIT = 2'd0,
      REQ_BCAST = 2'd1,
      REQ_CLEAR = 2'd2,
      REQ_TEXT  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      CSR_CHAIN_LENGTH = 2'd0,
      CSR_DIGIT_COUNT  = 2'd1,
      CSR_MIRRORED     = 2'd2,
      CSR_BCD_MODE     = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      OP_REJECT = 2'd0,
      OP_TARGET = 2'd1,
      OP_BCAST  = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] req_type;
      logic [5:0] digit_index;
      logic [3:0] reg_addr;
      logic [7:0] data_value;
      logic [7:0] text_char;
      logic       text_first;
      logic       text_last;
   } req_data_type;

   typedef struct packed {
      logic [15:0] frame_word;
      logic        frame_end;
      logic        run_last;
      logic        rejected;
   } rsp_data_type;

   // effective configuration seen by front and back
   typedef struct packed {
      logic [3:0] chain;
      logic [6:0] digits;
      logic       mirrored;
      logic       bcd_mode;
   } cfg_type;

   // one queued command: up to two targeted frames, or a broadcast/clear/reject
   typedef struct packed {
      op_type      op;
      logic        two;
      logic [2:0]  chip_a;
      logic [15:0] word_a;
      logic [2:0]  chip_b;
      logic [15:0] word_b;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef struct packed {
      logic [2:0]  chip;
      logic [15:0] word;
   } dframe_type;

   // digit position to chip and word, with optional mirroring
   function automatic dframe_type digit_frame(logic [6:0] pos, logic [7:0] val,
                                              logic [6:0] digits, logic mirror);
      logic [6:0] d;
      dframe_type f;
      d = mirror ? (digits - pos - 7'd1) : pos;
      f.chip = d[5:3];
      f.word = {4'b0000, {1'b0, d[2:0]} + 4'd1, val};
      return f;
   endfunction

   function automatic logic [7:0] bcd_code(logic [7:0] c);
      logic [7:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = c - 8'h30;
      end else begin
         unique case (c)
            8'h2D:        r = 8'h0A;
            8'h45, 8'h65: r = 8'h0B;
            8'h48, 8'h68: r = 8'h0C;
            8'h4C, 8'h6C: r = 8'h0D;
            8'h50, 8'h70: r = 8'h0E;
            default:      r = BLANK_CODE;
         endcase
      end
      return r;
   endfunction

endpackage

// ===== sv/ldf_csr.sv =====
module ldf_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready,
   output ldf_pkg::cfg_type     cfg
);

   logic [3:0] chain_length_ff;
   logic [6:0] digit_count_ff;
   logic       mirrored_ff;
   logic       bcd_mode_ff;
   logic       wr_en;
   logic [3:0] chain_eff;
   logic [6:0] cap;
   ldf_pkg::csr_idx_type idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = ldf_pkg::csr_idx_type'(paddr[3:2]);

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_length_ff <= 4'd1;
         digit_count_ff  <= 7'd0;
         mirrored_ff     <= 1'b0;
         bcd_mode_ff     <= 1'b0;
      end else if (wr_en) begin
         unique case (idx)
            ldf_pkg::CSR_CHAIN_LENGTH: chain_length_ff <= pwdata[3:0];
            ldf_pkg::CSR_DIGIT_COUNT:  digit_count_ff  <= pwdata[6:0];
            ldf_pkg::CSR_MIRRORED:     mirrored_ff     <= pwdata[0];
            ldf_pkg::CSR_BCD_MODE:     bcd_mode_ff     <= pwdata[0];
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (idx)
         ldf_pkg::CSR_CHAIN_LENGTH: prdata = {28'd0, chain_length_ff};
         ldf_pkg::CSR_DIGIT_COUNT:  prdata = {25'd0, digit_count_ff};
         ldf_pkg::CSR_MIRRORED:     prdata = {31'd0, mirrored_ff};
         ldf_pkg::CSR_BCD_MODE:     prdata = {31'd0, bcd_mode_ff};
      endcase
   end

   // effective chain and digit count
   always_comb begin
      if (chain_length_ff == 4'd0) begin
         chain_eff = 4'd1;
      end else if (chain_length_ff > 4'(ldf_pkg::CHAIN_CAP)) begin
         chain_eff = 4'(ldf_pkg::CHAIN_CAP);
      end else begin
         chain_eff = chain_length_ff;
      end
      cap = {chain_eff, 3'b000};
      cfg.chain    = chain_eff;
      cfg.digits   = (digit_count_ff == 7'd0 || digit_count_ff > cap) ? cap : digit_count_ff;
      cfg.mirrored = mirrored_ff;
      cfg.bcd_mode = bcd_mode_ff;
   end

endmodule

// ===== sv/ldf_front.sv =====
module ldf_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ldf_pkg::req_data_type req_data,
   input  ldf_pkg::cfg_type      cfg,
   input  ldf_pkg::q_stat_type   q_stat,
   output logic                  q_push,
   output ldf_pkg::cmd_type      q_cmd
);

   logic [6:0] pos_ff, pos_in;
   logic       pv_ff, pv_in;
   logic [7:0] code_ff, code_in;

   logic       accept;
   logic       has_cmd;
   ldf_pkg::req_kind_type kind;
   ldf_pkg::dframe_type   fr_d, fr_a, fr_b;

   // text path intermediates
   logic [6:0] pos0, pos1;
   logic       pv0, pv1;
   logic [7:0] code_a, code1;
   logic       dot_merge, emit_a, emit_b;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign q_push    = accept && has_cmd;
   assign kind      = ldf_pkg::req_kind_type'(req_data.req_type);

   // classify request, resolve text pending state
   always_comb begin
      q_cmd   = '0;
      has_cmd = 1'b1;
      pos_in  = pos_ff;
      pv_in   = pv_ff;
      code_in = code_ff;

      fr_d = ldf_pkg::digit_frame({1'b0, req_data.digit_index}, req_data.data_value,
                                  cfg.digits, cfg.mirrored);

      pos0      = req_data.text_first ? {1'b0, req_data.digit_index} : pos_ff;
      pv0       = req_data.text_first ? 1'b0 : pv_ff;
      dot_merge = (req_data.text_char == ldf_pkg::CHAR_DOT) && pv0;
      code_a    = dot_merge ? (code_ff | ldf_pkg::DP_BIT) : code_ff;
      emit_a    = pv0 && (pos0 < cfg.digits);
      fr_a      = ldf_pkg::digit_frame(pos0, code_a, cfg.digits, cfg.mirrored);
      pos1      = emit_a ? (pos0 + 7'd1) : pos0;
      if (req_data.text_char == ldf_pkg::CHAR_NUL || dot_merge) begin
         pv1   = 1'b0;
         code1 = code_a;
      end else begin
         pv1   = 1'b1;
         code1 = ldf_pkg::bcd_code(req_data.text_char);
      end
      emit_b = req_data.text_last && pv1 && (pos1 < cfg.digits);
      fr_b   = ldf_pkg::digit_frame(pos1, code1, cfg.digits, cfg.mirrored);

      unique case (kind)
         ldf_pkg::REQ_DIGIT: begin
            if ({1'b0, req_data.digit_index} >= cfg.digits) begin
               q_cmd.op = ldf_pkg::OP_REJECT;
            end else begin
               q_cmd.op     = ldf_pkg::OP_TARGET;
               q_cmd.chip_a = fr_d.chip;
               q_cmd.word_a = fr_d.word;
            end
         end
         ldf_pkg::REQ_BCAST: begin
            if (req_data.reg_addr == ldf_pkg::INTENSITY_REG &&
                req_data.data_value > ldf_pkg::MAX_INTENSITY) begin
               q_cmd.op = ldf_pkg::OP_REJECT;
            end else begin
               q_cmd.op     = ldf_pkg::OP_BCAST;
               q_cmd.word_a = {4'b0000, req_data.reg_addr, req_data.data_value};
            end
         end
         ldf_pkg::REQ_CLEAR: begin
            q_cmd.op     = ldf_pkg::OP_CLEAR;
            q_cmd.word_a = {8'h00, cfg.bcd_mode ? ldf_pkg::BLANK_CODE : 8'h00};
         end
         ldf_pkg::REQ_TEXT: begin
            if (!cfg.bcd_mode) begin
               q_cmd.op = ldf_pkg::OP_REJECT;
            end else begin
               q_cmd.op = ldf_pkg::OP_TARGET;
               has_cmd  = emit_a || emit_b;
               if (emit_a) begin
                  q_cmd.chip_a = fr_a.chip;
                  q_cmd.word_a = fr_a.word;
                  q_cmd.two    = emit_b;
                  q_cmd.chip_b = fr_b.chip;
                  q_cmd.word_b = fr_b.word;
               end else begin
                  q_cmd.chip_a = fr_b.chip;
                  q_cmd.word_a = fr_b.word;
               end
               pos_in  = emit_b ? (pos1 + 7'd1) : pos1;
               pv_in   = req_data.text_last ? 1'b0 : pv1;
               code_in = code1;
            end
         end
      endcase
   end

   // text state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= 7'd0;
         pv_ff   <= 1'b0;
         code_ff <= 8'h00;
      end else if (accept) begin
         pos_ff  <= pos_in;
         pv_ff   <= pv_in;
         code_ff <= code_in;
      end
   end

endmodule

// ===== sv/ldf_queue.sv =====
module ldf_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ldf_pkg::cmd_type    push_cmd,
   input  logic                pop,
   output ldf_pkg::cmd_type    head,
   output ldf_pkg::q_stat_type stat
);

   localparam int unsigned PTR_W = $clog2(ldf_pkg::QUEUE_DEPTH);
   localparam int unsigned CNT_W = $clog2(ldf_pkg::QUEUE_DEPTH + 1);

   ldf_pkg::cmd_type entry_ff [ldf_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign head       = entry_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CNT_W'(ldf_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   // pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

// ===== sv/ldf_back.sv =====
module ldf_back (
   input  logic                  clock,
   input  logic                  reset,
   input  ldf_pkg::cfg_type      cfg,
   input  ldf_pkg::cmd_type      head,
   input  ldf_pkg::q_stat_type   q_stat,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ldf_pkg::rsp_data_type rsp_data
);

   logic [2:0] chip_ff, frm_ff;
   logic       rsp_valid_ff;
   ldf_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [2:0]  chain_m1, frm_m1, cur_chip;
   logic [15:0] cur_word;
   logic        last_chip, done, load;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load      = !q_stat.empty && (!rsp_valid_ff || rsp_ready);
   assign q_pop     = load && done;

   // word for current chip and frame
   always_comb begin
      chain_m1  = 3'(cfg.chain - 4'd1);
      last_chip = (chip_ff == chain_m1);
      cur_chip  = frm_ff[0] ? head.chip_b : head.chip_a;
      cur_word  = frm_ff[0] ? head.word_b : head.word_a;
      frm_m1    = 3'd0;
      rsp_data_in = '0;
      unique case (head.op)
         ldf_pkg::OP_REJECT: begin
            rsp_data_in.rejected = 1'b1;
         end
         ldf_pkg::OP_TARGET: begin
            frm_m1 = {2'b00, head.two};
            rsp_data_in.frame_word = (chip_ff == cur_chip) ? cur_word : 16'h0000;
         end
         ldf_pkg::OP_BCAST: begin
            rsp_data_in.frame_word = head.word_a;
         end
         ldf_pkg::OP_CLEAR: begin
            frm_m1 = 3'd7;
            rsp_data_in.frame_word = {4'b0000, {1'b0, frm_ff} + 4'd1, head.word_a[7:0]};
         end
      endcase
      if (head.op == ldf_pkg::OP_REJECT) begin
         done = 1'b1;
      end else begin
         rsp_data_in.frame_end = last_chip;
         done = last_chip && (frm_ff == frm_m1);
      end
      rsp_data_in.run_last = done;
   end

   // frame and chip counters
   always_ff @(posedge clock) begin
      if (reset) begin
         chip_ff <= 3'd0;
         frm_ff  <= 3'd0;
      end else if (load) begin
         if (done) begin
            chip_ff <= 3'd0;
            frm_ff  <= 3'd0;
         end else if (last_chip) begin
            chip_ff <= 3'd0;
            frm_ff  <= frm_ff + 3'd1;
         end else begin
            chip_ff <= chip_ff + 3'd1;
         end
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

// ===== sv/led_digit_chain_command_framer.sv =====
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_ready   req_data (ldf_pkg::req_data_type)
// rsp       out        rsp_valid/rsp_ready   rsp_data (ldf_pkg::rsp_data_type)
// csr       in         psel/penable/pready   paddr, pwdata, prdata (32 bit)
//
// The back end sends one word per cycle while a command waits and rsp_ready allows:
// per chip a digit or register request gives one word, a clear 8, two-digit text 2.
// Requests are taken every cycle while the 4-entry command queue has room.
// Rejected requests give one word; text that only buffers a digit gives none.
// Reset is synchronous; it empties the queue and clears the text position.
// No clearing pass: the block takes requests in the cycle after reset.
`include "led_digit_chain_command_framer_defines.svh"

module led_digit_chain_command_framer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  ldf_pkg::req_data_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ldf_pkg::rsp_data_type rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [3:0]            paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   ldf_pkg::cfg_type    cfg;
   ldf_pkg::cmd_type    q_cmd, q_head;
   ldf_pkg::q_stat_type q_stat;
   logic                q_push, q_pop;

   ldf_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ldf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cfg       (cfg),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_cmd     (q_cmd)
   );

   ldf_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .pop      (q_pop),
      .head     (q_head),
      .stat     (q_stat)
   );

   ldf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (q_head),
      .q_stat    (q_stat),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // queue never overflows or underflows
   `LDF_ASSERT_NOW(a_no_overflow, clock, reset, q_push && !q_pop, !q_stat.full)
   `LDF_ASSERT_NOW(a_no_underflow, clock, reset, q_pop, !q_stat.empty)
   // a refused request is a single empty closing word
   `LDF_ASSERT_NOW(a_reject_shape, clock, reset, rsp_valid && rsp_data.rejected,
      rsp_data.run_last && !rsp_data.frame_end && rsp_data.frame_word == 16'h0000)
   // a command only finishes at a frame boundary
   `LDF_ASSERT_NOW(a_last_on_end, clock, reset,
      rsp_valid && rsp_data.run_last && !rsp_data.rejected, rsp_data.frame_end)
   // after a pop the queue has room for the next request
   `LDF_ASSERT_NEXT(a_pop_restart, clock, reset, q_pop, !q_stat.full)

endmodule
